>>> hdl/iirdf2_pkg.sv
// Package for the direct form II fixed-point IIR filter.
// Holds function codes, fixed-point shift constants and controller types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iirdf2_pkg;

  localparam int unsigned TapsDef  = 11;  // coefficients per side
  localparam int unsigned InShift  = 11;  // input sample scaling
  localparam int unsigned WShift   = 12;  // intermediate value scaling
  localparam int unsigned NumShift = 10;  // intermediate scaling for output taps
  localparam int unsigned OutShift = 8;   // output sum scaling
  localparam int unsigned WWidth   = 20;  // stored intermediate width

  typedef enum logic [1:0] {
    FUNC_FILTER   = 2'd0,
    FUNC_LOAD_NUM = 2'd1,
    FUNC_LOAD_DEN = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FB,
    S_FB_DRAIN,
    S_WRITE,
    S_NUM,
    S_NUM_DRAIN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;      // filter sample transfer: capture sample, set up feedback pass
    logic load_coef;  // coefficient load transfer
    logic mac_fb;     // issue one feedback multiply
    logic mac_num;    // issue one output multiply
    logic write_w;    // store intermediate value, set up output pass
    logic load_out;   // load output register
  } cmd_t;

  typedef struct packed {
    logic last_tap;
  } status_t;

endpackage

`default_nettype wire

>>> hdl/iirdf2_ctrl.sv
// Controller state machine for the direct form II IIR filter.
// Sequences the feedback and output passes; owns the handshakes. Uses iirdf2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iirdf2_ctrl import iirdf2_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] func_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (func_i == FUNC_FILTER)) state_d = S_FB;
      end
      S_FB: begin
        if (status_i.last_tap) state_d = S_FB_DRAIN;
      end
      S_FB_DRAIN:  state_d = S_WRITE;
      S_WRITE:     state_d = S_NUM;
      S_NUM: begin
        if (status_i.last_tap) state_d = S_NUM_DRAIN;
      end
      S_NUM_DRAIN: state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        cmd_o.start     = in_fire && (func_i == FUNC_FILTER);
        cmd_o.load_coef = in_fire && (func_i inside {FUNC_LOAD_NUM, FUNC_LOAD_DEN});
      end
      S_FB:    cmd_o.mac_fb  = 1'b1;
      S_WRITE: cmd_o.write_w = 1'b1;
      S_NUM:   cmd_o.mac_num = 1'b1;
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/iirdf2_datapath.sv
// Datapath for the direct form II IIR filter: coefficient tables, intermediate
// ring, one shared multiplier and a 32-bit accumulator. Uses iirdf2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iirdf2_datapath import iirdf2_pkg::*; #(
  parameter int unsigned TAPS = TapsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         func_i,
  input  wire logic signed [15:0] sample_in_i,
  input  wire logic [3:0]         coef_index_i,
  input  wire logic signed [31:0] coef_value_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  output logic signed [15:0]      sample_out_o
);

  localparam int unsigned KW = $clog2(TAPS);
  localparam logic [KW-1:0] LastIdx = KW'(TAPS - 1);

  logic signed [31:0]       num_q  [TAPS];
  logic signed [31:0]       den_q  [TAPS];
  logic signed [WWidth-1:0] ring_q [TAPS];

  logic [KW-1:0]      pos_q, k_q, rp_q;
  logic signed [15:0] sample_q;
  logic signed [31:0] acc_q, prod_q;
  logic               pv_q;
  logic signed [15:0] out_q;

  logic [KW-1:0]            coef_idx;
  logic                     coef_ok;
  logic signed [31:0]       coef_op;
  logic signed [WWidth-1:0] w_rd, w_op;
  logic signed [51:0]       prod_full;
  logic signed [31:0]       scaled, diff;
  logic signed [WWidth-1:0] w_new;
  logic [KW-1:0]            pos_prev, rp_prev, pos_next;

  assign coef_idx = KW'(coef_index_i);
  assign coef_ok  = (32'(coef_index_i) < TAPS);

  assign w_rd      = ring_q[rp_q];
  assign w_op      = cmd_i.mac_fb ? w_rd : (w_rd >>> NumShift);
  assign coef_op   = cmd_i.mac_fb ? den_q[k_q] : num_q[k_q];
  assign prod_full = coef_op * w_op;

  assign scaled = {{(32 - 16 - InShift){sample_q[15]}}, sample_q, {InShift{1'b0}}};
  assign diff   = scaled - acc_q;
  assign w_new  = diff[31 -: WWidth];  // arithmetic shift right by WShift

  assign pos_prev = (pos_q == '0) ? LastIdx : pos_q - 1'b1;
  assign rp_prev  = (rp_q == '0) ? LastIdx : rp_q - 1'b1;
  assign pos_next = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;

  assign status_o.last_tap = (k_q == LastIdx);
  assign sample_out_o      = out_q;

  // coefficient tables and ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        num_q[i]  <= '0;
        den_q[i]  <= '0;
        ring_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load_coef && coef_ok) begin
        if (func_i == FUNC_LOAD_NUM) num_q[coef_idx] <= coef_value_i;
        else                         den_q[coef_idx] <= coef_value_i;
      end
      if (cmd_i.write_w) ring_q[pos_q] <= w_new;
    end
  end

  // sequencing pointers and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      k_q   <= '0;
      rp_q  <= '0;
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= cmd_i.mac_fb || cmd_i.mac_num;
      if (cmd_i.start) begin
        k_q   <= KW'(1);
        rp_q  <= pos_prev;
        acc_q <= '0;
      end else if (cmd_i.write_w) begin
        k_q   <= '0;
        rp_q  <= pos_q;
        pos_q <= pos_next;
        acc_q <= '0;
      end else begin
        if (cmd_i.mac_fb || cmd_i.mac_num) begin
          k_q  <= k_q + 1'b1;
          rp_q <= rp_prev;
        end
        if (pv_q) acc_q <= acc_q + prod_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) sample_q <= sample_in_i;
    if (cmd_i.mac_fb || cmd_i.mac_num) prod_q <= prod_full[31:0];
    if (cmd_i.load_out) out_q <= acc_q[OutShift +: 16];
  end

endmodule

`default_nettype wire

>>> hdl/iir_direct_form_two_fixed_point.sv
// Direct form II fixed-point IIR filter, order TAPS-1, one shared multiplier.
// Input channel (in_valid_i / in_ready_o) carries func_i, sample_in_i,
// coef_index_i and coef_value_i; output channel (out_valid_o / out_ready_i)
// carries sample_out_o.
// A coefficient load transfer gives no result; an index of TAPS or above
// is dropped, as is func code 3.
// A filter transfer runs TAPS-1 feedback multiplies, one drain, one ring
// write, TAPS output multiplies and one drain through the single
// multiply-accumulate unit; the result is loaded into the output register,
// and the input accepts again in the next cycle. The input takes no new
// sample until the previous result has been loaded.
// The output register holds a finished result while the input side takes
// coefficient loads or the next sample; a stalled receiver only holds the
// next result back at its final step.
// Reset clears both coefficient tables, the intermediate ring, the ring
// position and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_two_fixed_point import iirdf2_pkg::*; #(
  parameter int unsigned TAPS = TapsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic signed [15:0] sample_in_i,
  input  wire logic [3:0]         coef_index_i,
  input  wire logic signed [31:0] coef_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      sample_out_o
);

  cmd_t    cmd;
  status_t status;

  iirdf2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  iirdf2_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire
